// File: sv/cta_pkg.sv
// Shared types, constants and month-length function for the time-zone adjust block.
`default_nettype none

package cta_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned LYearW  = 15;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned OffW    = 5;
  localparam int unsigned SumW    = 7;   // hour plus signed offset, -16..46

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 32;

  // Month numbers used by the carry/borrow logic
  localparam logic [MonthW-1:0] MONTH_JAN = 4'd1;
  localparam logic [MonthW-1:0] MONTH_FEB = 4'd2;
  localparam logic [MonthW-1:0] MONTH_MAR = 4'd3;
  localparam logic [MonthW-1:0] MONTH_APR = 4'd4;
  localparam logic [MonthW-1:0] MONTH_MAY = 4'd5;
  localparam logic [MonthW-1:0] MONTH_JUN = 4'd6;
  localparam logic [MonthW-1:0] MONTH_JUL = 4'd7;
  localparam logic [MonthW-1:0] MONTH_AUG = 4'd8;
  localparam logic [MonthW-1:0] MONTH_SEP = 4'd9;
  localparam logic [MonthW-1:0] MONTH_OCT = 4'd10;
  localparam logic [MonthW-1:0] MONTH_NOV = 4'd11;
  localparam logic [MonthW-1:0] MONTH_DEC = 4'd12;

  localparam logic [DayW-1:0] DAYS_31   = 5'd31;
  localparam logic [DayW-1:0] DAYS_30   = 5'd30;
  localparam logic [DayW-1:0] DAYS_29   = 5'd29;
  localparam logic [DayW-1:0] DAYS_28   = 5'd28;
  localparam logic [SumW-1:0] HOURS_DAY = 7'sd24;

  // Divisibility by 25 via the modular inverse: y*inv mod 2^14 <= (2^14-1)/25
  localparam logic [YearW-1:0] INV25_MOD = 14'd7209;
  localparam logic [YearW-1:0] DIV25_MAX = 14'd655;

  typedef struct packed {
    logic [HourW-1:0]  hour;
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } utc_item_t;

  typedef struct packed {
    logic [HourW-1:0]  hour;
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [LYearW-1:0] year;
  } local_item_t;

  // Gregorian month length; months outside 1..12 count as 30 days
  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                 input logic leap);
    logic [DayW-1:0] n;
    case (m)
      MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
      MONTH_AUG, MONTH_OCT, MONTH_DEC: n = DAYS_31;
      MONTH_FEB:                       n = leap ? DAYS_29 : DAYS_28;
      default:                         n = DAYS_30;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// File: sv/cta_leap_detect.sv
// Gregorian leap-year detection for a 14-bit year without a divider.
`default_nettype none

module cta_leap_detect import cta_pkg::*; (
  input  wire logic [YearW-1:0] year_i,
  output logic                  leap_o
);

  logic [YearW-1:0] prod;
  logic             div25;
  logic             div4;
  logic             div16;

  // multiply by inverse of 25 mod 2^14, divisible iff product stays small
  assign prod  = YearW'(year_i * INV25_MOD);
  assign div25 = (prod <= DIV25_MAX);
  assign div4  = (year_i[1:0] == 2'd0);
  assign div16 = (year_i[3:0] == 4'd0);

  // div 400 = div16 & div25; div 4 and not div 100 = div4 & !div25
  assign leap_o = div4 && (!div25 || div16);

endmodule

`default_nettype wire

// File: sv/cta_adjust.sv
// Hour offset, day carry/borrow, month and year roll for one UTC item.
`default_nettype none

module cta_adjust import cta_pkg::*; (
  input  wire utc_item_t         item_i,
  input  wire logic [OffW-1:0]   offset_i,
  output local_item_t            result_o
);

  logic signed [SumW-1:0] hour_sum;
  logic                   wrap_fwd;
  logic                   wrap_back;
  logic                   leap;
  logic [DayW-1:0]        len_cur;
  logic [DayW-1:0]        len_prev;
  logic [DayW:0]          day_inc;
  logic                   carry;
  logic                   borrow;
  logic [MonthW-1:0]      month_next;
  logic [MonthW-1:0]      month_prev;
  logic                   year_inc;
  logic                   year_dec;
  logic [LYearW-1:0]      year_ext;
  logic [SumW-1:0]        hour_adj;

  cta_leap_detect u_leap (
    .year_i (item_i.year),
    .leap_o (leap)
  );

  // hour plus sign-extended offset
  assign hour_sum  = $signed({2'b00, item_i.hour}) +
                     $signed({{(SumW-OffW){offset_i[OffW-1]}}, offset_i});
  assign wrap_fwd  = (hour_sum >= $signed(HOURS_DAY));
  assign wrap_back = hour_sum[SumW-1];

  // forward day step
  assign len_cur = month_days(item_i.month, leap);
  assign day_inc = {1'b0, item_i.day} + 6'd1;
  assign carry   = (day_inc > {1'b0, len_cur});
  assign year_inc   = (item_i.month >= MONTH_DEC);
  assign month_next = year_inc ? MONTH_JAN : item_i.month + 4'd1;

  // backward day step; a borrow into December never needs the leap flag
  assign borrow     = (item_i.day <= 5'd1);
  assign year_dec   = (item_i.month <= MONTH_JAN);
  assign month_prev = year_dec ? MONTH_DEC : item_i.month - 4'd1;
  assign len_prev   = month_days(month_prev, leap);

  assign year_ext = {1'b0, item_i.year};

  always_comb begin
    result_o.year  = year_ext;
    result_o.month = item_i.month;
    result_o.day   = item_i.day;
    hour_adj       = hour_sum;
    if (wrap_fwd) begin
      hour_adj = hour_sum - HOURS_DAY;
      if (carry) begin
        result_o.day   = 5'd1;
        result_o.month = month_next;
        if (year_inc) begin
          result_o.year = year_ext + 15'd1;
        end
      end else begin
        result_o.day = day_inc[DayW-1:0];
      end
    end else if (wrap_back) begin
      hour_adj = hour_sum + HOURS_DAY;
      if (borrow) begin
        result_o.month = month_prev;
        result_o.day   = len_prev;
        if (year_dec) begin
          result_o.year = year_ext - 15'd1;
        end
      end else begin
        result_o.day = item_i.day - 5'd1;
      end
    end
    result_o.hour = hour_adj[HourW-1:0];
  end

endmodule

`default_nettype wire

// File: sv/calendar_timezone_adjust_unit.sv
// Top level: offset register, input register, adjust logic and result register.
// An input transfer is held in the input register, then in the result register.
// Throughput: one item per cycle; the input stage also loads while it is empty, so the
// only limit is the downstream tready, which feeds back combinationally to s_axis_tready.
// Reset: rst_ni (async, low) empties both stages and sets the offset to 0 hours.
`default_nettype none

module calendar_timezone_adjust_unit import cta_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration
  input  wire logic                cfg_we_i,
  input  wire logic [OffW-1:0]     cfg_wdata_i,    // tz_offset_hours, signed
  // input stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,   // utc_year[13:0] utc_month[17:14]
                                                   // utc_day[22:18] utc_hour[27:23]
  // result stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata    // local_year[14:0] local_month[18:15]
                                                   // local_day[23:19] local_hour[28:24]
);

  logic [OffW-1:0] tz_offset_q;
  logic            in_valid_q;
  utc_item_t       in_q;
  logic            out_valid_q;
  local_item_t     out_q;
  local_item_t     result;
  logic            out_load;
  logic            in_load;

  // offset register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tz_offset_q <= '0;
    end else if (cfg_we_i) begin
      tz_offset_q <= cfg_wdata_i;
    end
  end

  // stage handshakes
  assign out_load      = !out_valid_q || m_axis_tready;
  assign in_load       = !in_valid_q || out_load;
  assign s_axis_tready = in_load;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && s_axis_tvalid) begin
      in_q <= s_axis_tdata[$bits(utc_item_t)-1:0];
    end
  end

  cta_adjust u_adjust (
    .item_i   (in_q),
    .offset_i (tz_offset_q),
    .result_o (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && in_valid_q) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-$bits(local_item_t)){1'b0}}, out_q};

  // adjusted hour always lands in 0..23 after the single wrap
  a_hour_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q.hour < 5'd24))
    else $error("local hour out of range");

  // an empty input stage never stalls the slave side
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input stage empty but not ready");

  // an item moving out of the input stage shows up as a result next cycle
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_load) |=> m_axis_tvalid)
    else $error("item lost between stages");

  // a blocked input stage holds its item
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_load) |=> (in_valid_q && $stable(in_q)))
    else $error("input stage changed while blocked");

endmodule

`default_nettype wire
